// File: src/fse_pkg.sv
// Shared types, widths and request codes of the Fourier series evaluator.
package fse_pkg;

    localparam int DEF_MAX_TERMS       = 16;
    localparam int DEF_ANGLE_BITS      = 16;
    localparam int DEF_SINE_INDEX_BITS = 10;

    localparam int COEFF_W    = 32;
    localparam int TAB_W      = 16;
    localparam int TRIG_W     = TAB_W + 1;
    localparam int ACC_W      = 64;
    localparam int OUT_W      = 48;
    localparam int CFG_W      = 5;
    localparam int FRAC_SHIFT = 15;

    // Exactly 1.0 in Q1.15.
    localparam logic [TAB_W-1:0] ONE_Q15 = 16'h8000;

    localparam logic [1:0] REQ_WR_COS = 2'd0;
    localparam logic [1:0] REQ_WR_SIN = 2'd1;
    localparam logic [1:0] REQ_EVAL   = 2'd2;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [3:0]                 term_index;
        logic signed [COEFF_W-1:0]  coeff_value;
        logic [15:0]                angle;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] potential;
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] curvature;
    } t_out;

    // Travels with each term slot down the term pipeline.
    typedef struct packed {
        logic valid;
        logic live;
        logic first;
        logic last;
    } t_term_tag;

endpackage

// File: src/fourier_series_evaluator.sv
// Top level of the truncated Fourier series evaluator with first and second derivatives.
//
// A coefficient write beat is stored as soon as it is taken. An evaluate beat issues n term
// slots, where n is the number of terms in use, capped at MAX_TERMS. When n is zero a single
// empty slot is issued. One harmonic term is issued per cycle. Each term passes through the
// sine table and coefficient read, harmonic scaling, the six coefficient multipliers, the
// term sums and the clamped accumulators, and the result then goes into the output register.
// The input stalls while an evaluation is in progress and until its result has moved into
// the output register, so evaluations do not overlap. Coefficient writes are accepted while
// an earlier result waits in the output register. Coefficients read as zero until written,
// and terms_in_use resets to zero.
module fourier_series_evaluator
    import fse_pkg::*;
#(
    parameter int MAX_TERMS       = DEF_MAX_TERMS,
    parameter int ANGLE_BITS      = DEF_ANGLE_BITS,
    parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int M_W   = $clog2(MAX_TERMS + 1);
    localparam int M2_W  = 2 * M_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CFG_W-1:0]      r_terms;
    logic [ANGLE_BITS-1:0] r_ang, r_h;
    logic [IDX_W-1:0]      r_k, r_klast;
    logic [M_W-1:0]        r_m, r_m1;
    logic [M2_W-1:0]       r_m2, r_m2_1;
    logic                  r_live;

    logic signed [COEFF_W-1:0] r_cos_mem [MAX_TERMS];
    logic signed [COEFF_W-1:0] r_sin_mem [MAX_TERMS];
    logic [MAX_TERMS-1:0]      r_cos_vld, r_sin_vld;
    logic signed [COEFF_W-1:0] r_cos_rd, r_sin_rd;
    logic                      r_cos_rd_vld, r_sin_rd_vld;

    t_term_tag             w_issue, r_tag1;
    logic                  r_out_valid;
    t_out                  r_out;

    logic                       w_in_acc, w_eval, w_wr_ok, w_out_free, w_load, w_done;
    logic [M_W-1:0]             w_n_eff;
    logic [IDX_W-1:0]           w_wr_idx;
    logic [SINE_INDEX_BITS-1:0] w_pos;
    logic signed [TRIG_W-1:0]   w_sin, w_cos;
    logic signed [COEFF_W-1:0]  w_a, w_b;
    t_out                       w_res;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_eval     = w_in_acc && (i_in.req_type == REQ_EVAL);
    assign w_wr_ok    = (32'(i_in.term_index) < MAX_TERMS);
    assign w_wr_idx   = IDX_W'(i_in.term_index);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = ((r_state == ST_WAIT && w_done) || r_state == ST_HOLD) && w_out_free;

    always_comb begin
        if (32'(r_terms) > MAX_TERMS) begin
            w_n_eff = M_W'(MAX_TERMS);
        end else begin
            w_n_eff = M_W'(r_terms);
        end
    end

    always_comb begin
        w_issue.valid = (r_state == ST_RUN);
        w_issue.live  = r_live;
        w_issue.first = (r_k == '0);
        w_issue.last  = !r_live || (r_k == r_klast);
    end

    // Harmonic angle rounded to the nearest sine table position, wrapping round a full turn.
    if (ANGLE_BITS > SINE_INDEX_BITS) begin : g_pos_round
        localparam int RSH = ANGLE_BITS - SINE_INDEX_BITS;
        localparam int HALF_STEP = 1 << (RSH - 1);
        logic [ANGLE_BITS-1:0] w_round;
        assign w_round = r_h + ANGLE_BITS'(HALF_STEP);
        assign w_pos   = w_round[ANGLE_BITS-1:RSH];
    end else if (ANGLE_BITS == SINE_INDEX_BITS) begin : g_pos_same
        assign w_pos = r_h;
    end else begin : g_pos_widen
        assign w_pos = {r_h, {(SINE_INDEX_BITS - ANGLE_BITS){1'b0}}};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_eval) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_issue.last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = w_out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_terms     <= '0;
            r_cos_vld   <= '0;
            r_sin_vld   <= '0;
            r_tag1      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tag1  <= w_issue;
            if (i_cfg_valid) begin
                r_terms <= i_cfg_data;
            end
            if (w_in_acc && w_wr_ok && i_in.req_type == REQ_WR_COS) begin
                r_cos_vld[w_wr_idx] <= 1'b1;
            end
            if (w_in_acc && w_wr_ok && i_in.req_type == REQ_WR_SIN) begin
                r_sin_vld[w_wr_idx] <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_ang   <= ANGLE_BITS'(i_in.angle);
            r_h     <= ANGLE_BITS'(i_in.angle);
            r_k     <= '0;
            r_klast <= IDX_W'(w_n_eff - 1'b1);
            r_m     <= M_W'(1);
            r_m2    <= M2_W'(1);
            r_live  <= (w_n_eff != '0);
        end else if (r_state == ST_RUN) begin
            // (m+1)^2 = m^2 + 2m + 1.
            r_h  <= r_h + r_ang;
            r_k  <= r_k + 1'b1;
            r_m  <= r_m + 1'b1;
            r_m2 <= r_m2 + M2_W'({r_m, 1'b1});
        end
        if (w_in_acc && w_wr_ok && i_in.req_type == REQ_WR_COS) begin
            r_cos_mem[w_wr_idx] <= i_in.coeff_value;
        end
        if (w_in_acc && w_wr_ok && i_in.req_type == REQ_WR_SIN) begin
            r_sin_mem[w_wr_idx] <= i_in.coeff_value;
        end
        r_cos_rd     <= r_cos_mem[r_k];
        r_sin_rd     <= r_sin_mem[r_k];
        r_cos_rd_vld <= r_cos_vld[r_k];
        r_sin_rd_vld <= r_sin_vld[r_k];
        r_m1         <= r_m;
        r_m2_1       <= r_m2;
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign w_a = r_cos_rd_vld ? r_cos_rd : '0;
    assign w_b = r_sin_rd_vld ? r_sin_rd : '0;

    fse_trig #(
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_trig (
        .i_clk (i_clk),
        .i_pos (w_pos),
        .o_sin (w_sin),
        .o_cos (w_cos)
    );

    fse_mac #(
        .MAX_TERMS (MAX_TERMS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag1),
        .i_sin   (w_sin),
        .i_cos   (w_cos),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_m     (r_m1),
        .i_m2    (r_m2_1),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_WAIT))
        else $error("term pipeline finished outside of the wait state");

    a_term_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_k <= r_klast))
        else $error("term counter ran past the last term");

    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eval |=> (r_state == ST_RUN))
        else $error("evaluate beat did not start the term sequence");

    a_tag_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag1.valid |-> ($past(r_state) == ST_RUN))
        else $error("term slot issued outside of the run state");

endmodule

// File: src/fse_trig.sv
// Quarter-wave sine table lookup giving registered sine and cosine of a table position.
module fse_trig
    import fse_pkg::*;
#(
    parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
) (
    input  logic                        i_clk,
    input  logic [SINE_INDEX_BITS-1:0]  i_pos,
    output logic signed [TRIG_W-1:0]    o_sin,
    output logic signed [TRIG_W-1:0]    o_cos
);

    localparam int QTR_BITS = SINE_INDEX_BITS - 2;
    localparam int QTR_LEN  = 1 << QTR_BITS;
    localparam int TIDX_W   = SINE_INDEX_BITS - 1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [1:7] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    // Taylor series of sine in Q30, rounded to Q1.15; evaluated at elaboration only.
    function automatic logic [TAB_W-1:0] qtab_entry(input int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        int              n;
        if (i == 0) begin
            return '0;
        end
        if (i == QTR_LEN) begin
            return ONE_Q15;
        end
        x    = (longint'(i) * HALF_PI_Q30) >> QTR_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[n];
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum + 16384) >>> 15;
        if (v > 32768) begin
            v = 32768;
        end
        return TAB_W'(v);
    endfunction

    logic [TAB_W-1:0] w_tab [0:QTR_LEN];

    for (genvar g = 0; g <= QTR_LEN; g++) begin : g_tab
        assign w_tab[g] = qtab_entry(g);
    end

    logic [1:0]          w_quad_s;
    logic [1:0]          w_quad_c;
    logic [QTR_BITS-1:0] w_rem;
    logic [TIDX_W-1:0]   w_idx_s;
    logic [TIDX_W-1:0]   w_idx_c;
    logic [TAB_W-1:0]    w_mag_s;
    logic [TAB_W-1:0]    w_mag_c;

    // Cosine is the sine one quadrant further on, with the same remainder.
    always_comb begin
        w_quad_s = i_pos[SINE_INDEX_BITS-1 -: 2];
        w_quad_c = w_quad_s + 2'd1;
        w_rem    = i_pos[QTR_BITS-1:0];
        w_idx_s  = w_quad_s[0] ? (TIDX_W'(QTR_LEN) - TIDX_W'(w_rem)) : TIDX_W'(w_rem);
        w_idx_c  = w_quad_c[0] ? (TIDX_W'(QTR_LEN) - TIDX_W'(w_rem)) : TIDX_W'(w_rem);
        w_mag_s  = w_tab[w_idx_s];
        w_mag_c  = w_tab[w_idx_c];
    end

    always_ff @(posedge i_clk) begin
        o_sin <= w_quad_s[1] ? -$signed({1'b0, w_mag_s}) : $signed({1'b0, w_mag_s});
        o_cos <= w_quad_c[1] ? -$signed({1'b0, w_mag_c}) : $signed({1'b0, w_mag_c});
    end

endmodule

// File: src/fse_mac.sv
// Term pipeline: harmonic scaling, six coefficient products, term sums and clamped accumulators.
module fse_mac
    import fse_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_term_tag                    i_tag,
    input  logic signed [TRIG_W-1:0]     i_sin,
    input  logic signed [TRIG_W-1:0]     i_cos,
    input  logic signed [COEFF_W-1:0]    i_a,
    input  logic signed [COEFF_W-1:0]    i_b,
    input  logic [$clog2(MAX_TERMS+1)-1:0]    i_m,
    input  logic [2*$clog2(MAX_TERMS+1)-1:0]  i_m2,
    output logic                         o_done,
    output t_out                         o_res
);

    localparam int M_W   = $clog2(MAX_TERMS + 1);
    localparam int M2_W  = 2 * M_W;
    localparam int OMC_W = TRIG_W + 1;
    localparam int MS_W  = TRIG_W + M_W + 1;
    localparam int M2S_W = TRIG_W + M2_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_LIMIT = ACC_W'(1) <<< 62;
    localparam logic signed [ACC_W-1:0] ACC_NEG   = -ACC_LIMIT;
    localparam logic signed [ACC_W-1:0] OUT_MAX   = (ACC_W'(1) <<< (OUT_W - 1)) - 1;
    localparam logic signed [ACC_W-1:0] OUT_MIN   = ~OUT_MAX;

    function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [ACC_W-1:0] v);
        if (v > ACC_LIMIT) begin
            return ACC_LIMIT;
        end
        if (v < ACC_NEG) begin
            return ACC_NEG;
        end
        return v;
    endfunction

    // Arithmetic shift floors, then saturate to the output width.
    function automatic logic signed [OUT_W-1:0] finish_sum(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        q = acc >>> FRAC_SHIFT;
        if (q > OUT_MAX) begin
            q = OUT_MAX;
        end else if (q < OUT_MIN) begin
            q = OUT_MIN;
        end
        return q[OUT_W-1:0];
    endfunction

    t_term_tag r_tag2, r_tag3, r_tag4;

    logic signed [COEFF_W-1:0] r_a2, r_b2;
    logic signed [TRIG_W-1:0]  r_s2;
    logic signed [OMC_W-1:0]   r_omc;
    logic signed [MS_W-1:0]    r_ms, r_mc;
    logic signed [M2S_W-1:0]   r_m2s, r_m2c;

    logic signed [COEFF_W+OMC_W-1:0]  r_p_aomc;
    logic signed [COEFF_W+TRIG_W-1:0] r_p_bs;
    logic signed [COEFF_W+MS_W-1:0]   r_p_ams, r_p_bmc;
    logic signed [COEFF_W+M2S_W-1:0]  r_p_am2c, r_p_bm2s;

    logic signed [ACC_W-1:0] r_t_pot, r_t_d1, r_t_d2;
    logic signed [ACC_W-1:0] r_acc_pot, r_acc_d1, r_acc_d2;

    logic signed [ACC_W-1:0] w_base_pot, w_base_d1, w_base_d2;
    logic signed [ACC_W-1:0] w_add_pot, w_add_d1, w_add_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            o_done <= 1'b0;
        end else begin
            r_tag2 <= i_tag;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            o_done <= r_tag4.valid && r_tag4.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a2  <= i_a;
        r_b2  <= i_b;
        r_s2  <= i_sin;
        r_omc <= $signed({2'b00, ONE_Q15}) - OMC_W'(i_cos);
        r_ms  <= $signed({1'b0, i_m}) * i_sin;
        r_mc  <= $signed({1'b0, i_m}) * i_cos;
        r_m2s <= $signed({1'b0, i_m2}) * i_sin;
        r_m2c <= $signed({1'b0, i_m2}) * i_cos;

        r_p_aomc <= r_a2 * r_omc;
        r_p_bs   <= r_b2 * r_s2;
        r_p_ams  <= r_a2 * r_ms;
        r_p_bmc  <= r_b2 * r_mc;
        r_p_am2c <= r_a2 * r_m2c;
        r_p_bm2s <= r_b2 * r_m2s;

        r_t_pot <= ACC_W'(r_p_aomc) + ACC_W'(r_p_bs);
        r_t_d1  <= ACC_W'(r_p_ams) + ACC_W'(r_p_bmc);
        r_t_d2  <= ACC_W'(r_p_am2c) - ACC_W'(r_p_bm2s);
    end

    // The first slot of an evaluation starts from zero; a slot with no terms adds nothing.
    always_comb begin
        w_base_pot = r_tag4.first ? '0 : r_acc_pot;
        w_base_d1  = r_tag4.first ? '0 : r_acc_d1;
        w_base_d2  = r_tag4.first ? '0 : r_acc_d2;
        w_add_pot  = r_tag4.live ? r_t_pot : '0;
        w_add_d1   = r_tag4.live ? r_t_d1 : '0;
        w_add_d2   = r_tag4.live ? r_t_d2 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (r_tag4.valid) begin
            r_acc_pot <= clamp_acc(w_base_pot + w_add_pot);
            r_acc_d1  <= clamp_acc(w_base_d1 + w_add_d1);
            r_acc_d2  <= clamp_acc(w_base_d2 + w_add_d2);
        end
    end

    always_comb begin
        o_res.potential = finish_sum(r_acc_pot);
        o_res.slope     = finish_sum(r_acc_d1);
        o_res.curvature = finish_sum(r_acc_d2);
    end

endmodule

// File: tb/fse_checker.sv
// Scoreboard for the Fourier series evaluator: predicts every evaluation and checks each result.
module fse_checker
    import fse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in              i_in,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out             i_out,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_sums_pending
);

    localparam int QTR         = 1 << (DEF_SINE_INDEX_BITS - 2);
    localparam int FULL        = 1 << DEF_SINE_INDEX_BITS;
    localparam int ANGLE_MASK  = (1 << DEF_ANGLE_BITS) - 1;
    localparam int ROUND_SHIFT = DEF_ANGLE_BITS - DEF_SINE_INDEX_BITS;
    localparam int MAX_REPORTS = 10;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint ACC_CAP = 64'sd1 <<< 62;
    localparam longint Q48_MAX = (64'sd1 <<< 47) - 1;
    localparam longint Q48_MIN = -(64'sd1 <<< 47);

    int                        quarter_sine [0:QTR];
    logic signed [COEFF_W-1:0] cos_coef [0:DEF_MAX_TERMS-1];
    logic signed [COEFF_W-1:0] sin_coef [0:DEF_MAX_TERMS-1];
    logic [CFG_W-1:0]          terms;
    t_out                      expected_sums [$];
    int                        fail_total = 0;

    assign o_fail_count = fail_total;

    // Quarter-wave sine in Q1.15, from a Q30 Taylor series up to x^15.
    initial begin
        longint unsigned x, x2, term;
        longint sum, v;
        for (int i = 0; i <= QTR; i++) begin
            x = longint'(i);
            x = (x * HALF_PI_Q30) / QTR;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            if (sum < 0) sum = 0;
            v = (sum + 16384) >>> 15;
            if (v > 32768) v = 32768;
            quarter_sine[i] = int'(v);
        end
        quarter_sine[0] = 0;
        quarter_sine[QTR] = 32768;
    end

    function automatic longint sine_at(input int unsigned pos);
        int unsigned p, r;
        p = pos % FULL;
        r = p % QTR;
        case (p / QTR)
            0: return longint'(quarter_sine[r]);
            1: return longint'(quarter_sine[QTR - r]);
            2: return -longint'(quarter_sine[r]);
            default: return -longint'(quarter_sine[QTR - r]);
        endcase
    endfunction

    function automatic longint clamp_acc(input longint acc);
        if (acc > ACC_CAP) return ACC_CAP;
        if (acc < -ACC_CAP) return -ACC_CAP;
        return acc;
    endfunction

    // Floor to Q32.16 and saturate to the 48-bit output range.
    function automatic logic signed [OUT_W-1:0] to_q48(input longint acc);
        longint q;
        q = acc >>> FRAC_SHIFT;
        if (q > Q48_MAX) q = Q48_MAX;
        if (q < Q48_MIN) q = Q48_MIN;
        return q[OUT_W-1:0];
    endfunction

    function automatic t_out series_sums(input logic [15:0] ang);
        longint pot, d1, d2, s, c, a, b, m, m2;
        int n;
        int unsigned h, pos;
        t_out r;
        pot = 0;
        d1 = 0;
        d2 = 0;
        n = (terms > DEF_MAX_TERMS) ? DEF_MAX_TERMS : int'(terms);
        for (int k = 0; k < n; k++) begin
            h = ((k + 1) * ang) & ANGLE_MASK;
            pos = ((h + (1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT) % FULL;
            s = sine_at(pos);
            c = sine_at(pos + QTR);
            a = longint'(cos_coef[k]);
            b = longint'(sin_coef[k]);
            m = longint'(k + 1);
            m2 = m * m;
            pot = clamp_acc(pot + a * (32768 - c) + b * s);
            d1 = clamp_acc(d1 + a * (m * s) + b * (m * c));
            d2 = clamp_acc(d2 + a * (m2 * c) - b * (m2 * s));
        end
        r.potential = to_q48(pot);
        r.slope = to_q48(d1);
        r.curvature = to_q48(d2);
        return r;
    endfunction

    task automatic flag_failure(input string msg);
        fail_total++;
        if (fail_total <= MAX_REPORTS) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_out got, want;
        if (!i_rst_n) begin
            for (int k = 0; k < DEF_MAX_TERMS; k++) begin
                cos_coef[k] = '0;
                sin_coef[k] = '0;
            end
            terms = '0;
            expected_sums.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out;
                if (expected_sums.size() == 0) begin
                    flag_failure($sformatf(
                        "%0t: result beat with no evaluation pending: %0d %0d %0d",
                        $time, got.potential, got.slope, got.curvature));
                end else begin
                    want = expected_sums.pop_front();
                    if (got.potential !== want.potential)
                        flag_failure($sformatf("%0t: potential expected %0d, got %0d",
                                               $time, want.potential, got.potential));
                    if (got.slope !== want.slope)
                        flag_failure($sformatf("%0t: slope expected %0d, got %0d",
                                               $time, want.slope, got.slope));
                    if (got.curvature !== want.curvature)
                        flag_failure($sformatf("%0t: curvature expected %0d, got %0d",
                                               $time, want.curvature, got.curvature));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in.req_type)
                    REQ_WR_COS: cos_coef[i_in.term_index] = i_in.coeff_value;
                    REQ_WR_SIN: sin_coef[i_in.term_index] = i_in.coeff_value;
                    REQ_EVAL: expected_sums.insert(expected_sums.size(),
                                                   series_sums(i_in.angle));
                    default: ;
                endcase
            end
            if (i_cfg_valid && i_cfg_ready) terms = i_cfg_data;
        end
        o_sums_pending <= expected_sums.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the Fourier series evaluator testbench: clock, reset, stimulus and verdict.
module tb_top;
    import fse_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = DEF_MAX_TERMS + 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LONG_HOLD       = 300;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 138;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in              in_beat = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out             out_beat;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    int               fail_count;
    int               sums_pending;
    int               quiet_cycles = 0;
    logic             idling = 1'b1;
    logic             rx_long_hold = 1'b0;
    logic [CFG_W-1:0] phase_terms [0:PHASES-1] =
        '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8, 5'd3, 5'd16};

    fourier_series_evaluator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    fse_checker sums_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in           (in_beat),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out          (out_beat),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_sums_pending (sums_pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic t_in make_req(input logic [1:0] req, input logic [3:0] idx,
                                     input logic [31:0] coeff, input logic [15:0] ang);
        t_in r;
        r.req_type = req;
        r.term_index = idx;
        r.coeff_value = coeff;
        r.angle = ang;
        return r;
    endfunction

    // Mostly evaluations and coefficient writes, with extreme values mixed in.
    function automatic t_in random_request();
        int unsigned pick;
        logic [1:0] req;
        logic [31:0] coeff;
        logic [15:0] ang;
        pick = $urandom_range(0, 99);
        if (pick < 4) req = REQ_UNUSED;
        else if (pick < 45) req = REQ_EVAL;
        else if (pick < 72) req = REQ_WR_COS;
        else req = REQ_WR_SIN;
        case ($urandom_range(0, 9))
            0: coeff = 32'h7FFF_FFFF;
            1: coeff = 32'h8000_0000;
            2: coeff = $urandom_range(0, 131072) - 65536;
            default: coeff = $urandom();
        endcase
        case ($urandom_range(0, 9))
            0: ang = 16'($urandom_range(0, 3) << 14);
            1: ang = 16'hFFFF;
            default: ang = 16'($urandom_range(0, 65535));
        endcase
        return make_req(req, 4'($urandom_range(0, 15)), coeff, ang);
    endfunction

    // Returns in the cycle the beat is taken, with valid still high.
    task automatic send_item(input t_in item);
        int unsigned gap;
        gap = idling ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_beat <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sums_pending != 0);
    endtask

    task automatic set_terms(input logic [CFG_W-1:0] value);
        wait_drained();
        // A write taken just before may still be working its way through.
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int unsigned gap;
        forever begin
            if (rx_long_hold) begin
                gap = LONG_HOLD;
                rx_long_hold = 1'b0;
            end else begin
                gap = idling ? $urandom_range(0, 8) : 0;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                    || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // With no terms in use an evaluation sums nothing.
        send_item(make_req(REQ_EVAL, 4'd3, 32'h1234_5678, 16'h1234));
        set_terms(5'd16);
        send_item(make_req(REQ_WR_COS, 4'd0, 32'h7FFF_FFFF, 16'h0000));
        send_item(make_req(REQ_WR_SIN, 4'd0, 32'h8000_0000, 16'hFFFF));
        send_item(make_req(REQ_WR_COS, 4'd15, 32'h8000_0000, 16'h0000));
        send_item(make_req(REQ_WR_SIN, 4'd15, 32'h7FFF_FFFF, 16'hFFFF));
        send_item(make_req(REQ_WR_COS, 4'd7, 32'h0001_0000, 16'h0000));
        send_item(make_req(REQ_WR_SIN, 4'd3, 32'hFFFF_0000, 16'h0000));
        send_item(make_req(REQ_EVAL, 4'd0, 32'h0, 16'h0000));
        send_item(make_req(REQ_EVAL, 4'd15, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(make_req(REQ_EVAL, 4'd0, 32'h0, 16'h4000));
        send_item(make_req(REQ_EVAL, 4'd0, 32'h0, 16'h8000));
        send_item(make_req(REQ_EVAL, 4'd0, 32'h0, 16'hC000));
        // Harmonic angles on either side of a table rounding boundary.
        send_item(make_req(REQ_EVAL, 4'd0, 32'h0, 16'h0020));
        send_item(make_req(REQ_EVAL, 4'd0, 32'h0, 16'h001F));
        // The unused request code must be dropped without a result.
        send_item(make_req(REQ_UNUSED, 4'd15, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(make_req(REQ_EVAL, 4'd5, 32'h0, 16'h5555));

        phase_terms[6] = CFG_W'($urandom_range(2, 15));
        for (int ph = 0; ph < PHASES; ph++) begin
            set_terms(phase_terms[ph]);
            idling = (ph % 3 != 1);
            // Hold the output long enough for evaluations to back up into the input.
            if (ph == 2) rx_long_hold = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2 || $urandom_range(0, 149) == 0) wait_drained();
                send_item(random_request());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
